// ===== rtl/core/sacl_pkg.sv =====
package sacl_pkg;

  // default geometry
  localparam int MAX_SET_BITS_DEF = 6;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int ADDR_WIDTH_DEF   = 32;

  // fixed field widths
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

  // configuration reset values
  localparam logic [2:0] SET_BITS_RST   = 3'd4;
  localparam logic [4:0] BLOCK_BITS_RST = 5'd4;
  localparam logic [3:0] WAYS_RST       = 4'd1;

  // request queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_MODIFY = 2'd2,
    CMD_IFETCH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  // back-end status seen by the front end
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

endpackage

// ===== rtl/core/sacl_in_if.sv =====
interface sacl_in_if import sacl_pkg::*; #(
  parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            command;
  logic [ADDR_WIDTH-1:0] address;

  modport source (output valid, command, address, input ready);
  modport sink   (input valid, command, address, output ready);
endinterface

// ===== rtl/core/sacl_out_if.sv =====
interface sacl_out_if import sacl_pkg::*;;
  logic             valid;
  logic             ready;
  logic [1:0]       outcome;
  logic             second_hit;
  logic [CNT_W-1:0] hit_total;
  logic [CNT_W-1:0] miss_total;
  logic [CNT_W-1:0] eviction_total;

  modport source (output valid, outcome, second_hit, hit_total, miss_total, eviction_total,
                  input ready);
  modport sink   (input valid, outcome, second_hit, hit_total, miss_total, eviction_total,
                  output ready);
endinterface

// ===== rtl/core/sacl_cfg_if.sv =====
interface sacl_cfg_if import sacl_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/sacl_front.sv =====
module sacl_front import sacl_pkg::*; #(
  parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = MAX_WAYS_DEF,
  parameter int ADDR_WIDTH   = ADDR_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  sacl_in_if.sink                               in_if,
  sacl_cfg_if.sink                              cfg_if,
  input  back_stat_t                            bstat,
  output logic                                  q_valid,
  output logic                                  q_modify,
  output logic [MAX_SET_BITS-1:0]               q_set,
  output logic [ADDR_WIDTH-1:0]                 q_tag,
  output logic [$clog2(MAX_WAYS+1)-1:0]         q_ways
);

  localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1);

  logic [2:0] set_bits_r;
  logic [4:0] block_bits_r;
  logic [3:0] ways_r;

  logic [4:0]                           s_eff;
  logic [5:0]                           tag_sh;
  logic [MAX_SET_BITS-1:0]              set_keep;
  logic [ADDR_WIDTH+MAX_SET_BITS-1:0]   set_sh;
  logic [MAX_SET_BITS-1:0]              set_d;
  logic [ADDR_WIDTH-1:0]                tag_d;
  logic [WAY_CNT_W-1:0]                 ways_d;
  logic                                 push;

  logic                    q_modify_r [Q_DEPTH];
  logic [MAX_SET_BITS-1:0] q_set_r    [Q_DEPTH];
  logic [ADDR_WIDTH-1:0]   q_tag_r    [Q_DEPTH];
  logic [WAY_CNT_W-1:0]    q_ways_r   [Q_DEPTH];
  logic [Q_PTR_W-1:0]      wr_ptr_r;
  logic [Q_PTR_W-1:0]      rd_ptr_r;
  logic [Q_CNT_W-1:0]      cnt_r;
  logic [Q_CNT_W-1:0]      cnt_nxt;

  // configuration registers, always writable
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= SET_BITS_RST;
      block_bits_r <= BLOCK_BITS_RST;
      ways_r       <= WAYS_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_SET_BITS:   set_bits_r   <= cfg_if.data[2:0];
        CFG_BLOCK_BITS: block_bits_r <= cfg_if.data;
        CFG_WAYS:       ways_r       <= cfg_if.data[3:0];
        default: ;
      endcase
    end
  end

  // address split: set index and tag
  always_comb begin
    s_eff = (5'(set_bits_r) > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS) : 5'(set_bits_r);
    for (int i = 0; i < MAX_SET_BITS; i++) begin
      set_keep[i] = (5'(i) < s_eff);
    end
    set_sh = {{MAX_SET_BITS{1'b0}}, in_if.address} >> block_bits_r;
    set_d  = set_sh[MAX_SET_BITS-1:0] & set_keep;
    tag_sh = 6'(block_bits_r) + 6'(s_eff);
    tag_d  = in_if.address >> tag_sh;
  end

  // ways clamped to 1..MAX_WAYS
  always_comb begin
    if (ways_r == 4'd0) begin
      ways_d = WAY_CNT_W'(1);
    end else if (5'(ways_r) > 5'(MAX_WAYS)) begin
      ways_d = WAY_CNT_W'(MAX_WAYS);
    end else begin
      ways_d = WAY_CNT_W'(ways_r);
    end
  end

  // instruction fetches are taken and dropped here
  assign in_if.ready = !bstat.clearing && (cnt_r != Q_CNT_W'(Q_DEPTH));
  assign push        = in_if.valid && in_if.ready && (in_if.command != CMD_IFETCH);

  // request queue
  always_comb begin
    cnt_nxt = cnt_r + Q_CNT_W'(push) - Q_CNT_W'(bstat.pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (bstat.pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_modify_r[wr_ptr_r] <= (in_if.command == CMD_MODIFY);
      q_set_r[wr_ptr_r]    <= set_d;
      q_tag_r[wr_ptr_r]    <= tag_d;
      q_ways_r[wr_ptr_r]   <= ways_d;
    end
  end

  assign q_valid  = (cnt_r != '0);
  assign q_modify = q_modify_r[rd_ptr_r];
  assign q_set    = q_set_r[rd_ptr_r];
  assign q_tag    = q_tag_r[rd_ptr_r];
  assign q_ways   = q_ways_r[rd_ptr_r];

endmodule

// ===== rtl/core/sacl_back.sv =====
module sacl_back import sacl_pkg::*; #(
  parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = MAX_WAYS_DEF,
  parameter int ADDR_WIDTH   = ADDR_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  logic                          q_modify,
  input  logic [MAX_SET_BITS-1:0]       q_set,
  input  logic [ADDR_WIDTH-1:0]         q_tag,
  input  logic [$clog2(MAX_WAYS+1)-1:0] q_ways,
  output back_stat_t                    bstat,
  sacl_out_if.source                    out_if
);

  localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1);
  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RANK_W    = WAY_W;
  localparam int NUM_SETS  = 1 << MAX_SET_BITS;

  typedef enum logic [1:0] {ST_CLEAR, ST_READ, ST_EXEC} state_t;

  state_t state_r;
  logic [MAX_SET_BITS-1:0] clr_idx_r;

  // set memory: one row per set holds every way
  logic [MAX_WAYS-1:0]                 mem_vld  [NUM_SETS];
  logic [MAX_WAYS-1:0][RANK_W-1:0]     mem_rank [NUM_SETS];
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] mem_tag  [NUM_SETS];

  logic [MAX_WAYS-1:0]                 rd_vld_r;
  logic [MAX_WAYS-1:0][RANK_W-1:0]     rd_rank_r;
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] rd_tag_r;

  // request being worked on
  logic                    it_modify_r;
  logic [MAX_SET_BITS-1:0] it_set_r;
  logic [ADDR_WIDTH-1:0]   it_tag_r;
  logic [WAY_CNT_W-1:0]    it_ways_r;

  logic             out_vld_r;
  outcome_t         out_outcome_r;
  logic             out_second_r;
  logic [CNT_W-1:0] hit_cnt_r;
  logic [CNT_W-1:0] miss_cnt_r;
  logic [CNT_W-1:0] evict_cnt_r;
  logic [CNT_W-1:0] hit_cnt_nxt;
  logic [CNT_W-1:0] miss_cnt_nxt;
  logic [CNT_W-1:0] evict_cnt_nxt;

  logic [MAX_WAYS-1:0] in_way;
  logic [MAX_WAYS-1:0] hit_vec;
  logic [MAX_WAYS-1:0] free_vec;
  logic                any_hit;
  logic                any_free;
  logic [WAY_W-1:0]    hit_w;
  logic [WAY_W-1:0]    free_w;
  logic [WAY_W-1:0]    vic_w;
  logic [WAY_W-1:0]    tgt_w;
  logic [RANK_W:0]     old_rank;
  outcome_t            outcome;

  logic [MAX_WAYS-1:0]                 new_vld;
  logic [MAX_WAYS-1:0][RANK_W-1:0]     new_rank;
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] new_tag;

  logic [1:0]       hit_inc;
  logic [CNT_W:0]   hit_sum;

  logic                    exec_fire;
  logic                    mem_we;
  logic [MAX_SET_BITS-1:0] mem_waddr;

  assign bstat.pop      = (state_r == ST_READ) && q_valid;
  assign bstat.clearing = (state_r == ST_CLEAR);
  assign exec_fire      = (state_r == ST_EXEC) && (!out_vld_r || out_if.ready);

  // way match, first free way, LRU victim
  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      in_way[i]   = (WAY_CNT_W'(i) < it_ways_r);
      hit_vec[i]  = rd_vld_r[i] && in_way[i] && (rd_tag_r[i] == it_tag_r);
      free_vec[i] = !rd_vld_r[i] && in_way[i];
    end
    any_hit  = |hit_vec;
    any_free = |free_vec;

    hit_w  = '0;
    free_w = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i])  hit_w  = WAY_W'(i);
      if (free_vec[i]) free_w = WAY_W'(i);
    end

    // strict greater keeps the lowest way on a tie
    vic_w = '0;
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (in_way[i] && (rd_rank_r[i] > rd_rank_r[vic_w])) vic_w = WAY_W'(i);
    end

    priority if (any_hit) begin
      tgt_w    = hit_w;
      old_rank = {1'b0, rd_rank_r[hit_w]};
      outcome  = OUT_HIT;
    end else if (any_free) begin
      tgt_w    = free_w;
      old_rank = (RANK_W+1)'(MAX_WAYS);
      outcome  = OUT_FILL;
    end else begin
      tgt_w    = vic_w;
      old_rank = {1'b0, rd_rank_r[vic_w]};
      outcome  = OUT_EVICT;
    end
  end

  // row write-back: touched line becomes most recent, younger lines age
  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      new_vld[i]  = rd_vld_r[i];
      new_rank[i] = rd_rank_r[i];
      new_tag[i]  = rd_tag_r[i];
      if (WAY_W'(i) == tgt_w) begin
        new_vld[i]  = 1'b1;
        new_rank[i] = '0;
        if (!any_hit) new_tag[i] = it_tag_r;
      end else if (rd_vld_r[i] && ({1'b0, rd_rank_r[i]} < old_rank) &&
                   ({1'b0, rd_rank_r[i]} < (RANK_W+1)'(MAX_WAYS - 1))) begin
        new_rank[i] = rd_rank_r[i] + 1'b1;
      end
    end
  end

  // saturating totals
  always_comb begin
    hit_inc = {1'b0, any_hit} + {1'b0, it_modify_r};
    hit_sum = {1'b0, hit_cnt_r} + (CNT_W+1)'(hit_inc);
    hit_cnt_nxt   = hit_sum[CNT_W] ? '1 : hit_sum[CNT_W-1:0];
    miss_cnt_nxt  = (!any_hit && (miss_cnt_r != '1)) ? miss_cnt_r + 1'b1 : miss_cnt_r;
    evict_cnt_nxt = (!any_hit && !any_free && (evict_cnt_r != '1)) ?
                    evict_cnt_r + 1'b1 : evict_cnt_r;
  end

  assign mem_we    = (state_r == ST_CLEAR) || exec_fire;
  assign mem_waddr = (state_r == ST_CLEAR) ? clr_idx_r : it_set_r;

  // set memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      if (state_r == ST_CLEAR) begin
        mem_vld[mem_waddr]  <= '0;
        mem_rank[mem_waddr] <= '0;
        mem_tag[mem_waddr]  <= '0;
      end else begin
        mem_vld[mem_waddr]  <= new_vld;
        mem_rank[mem_waddr] <= new_rank;
        mem_tag[mem_waddr]  <= new_tag;
      end
    end
    if (bstat.pop) begin
      rd_vld_r  <= mem_vld[q_set];
      rd_rank_r <= mem_rank[q_set];
      rd_tag_r  <= mem_tag[q_set];
    end
  end

  // sequencer: clear, read set, execute and write back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      out_vld_r   <= 1'b0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
    end else begin
      if (out_if.ready && !exec_fire) out_vld_r <= 1'b0;
      unique case (state_r)
        ST_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (&clr_idx_r) state_r <= ST_READ;
        end
        ST_READ: begin
          if (q_valid) begin
            it_modify_r <= q_modify;
            it_set_r    <= q_set;
            it_tag_r    <= q_tag;
            it_ways_r   <= q_ways;
            state_r     <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_fire) begin
            out_vld_r     <= 1'b1;
            out_outcome_r <= outcome;
            out_second_r  <= it_modify_r;
            hit_cnt_r     <= hit_cnt_nxt;
            miss_cnt_r    <= miss_cnt_nxt;
            evict_cnt_r   <= evict_cnt_nxt;
            state_r       <= ST_READ;
          end
        end
        default: state_r <= ST_CLEAR;
      endcase
    end
  end

  assign out_if.valid          = out_vld_r;
  assign out_if.outcome        = out_outcome_r;
  assign out_if.second_hit     = out_second_r;
  assign out_if.hit_total      = hit_cnt_r;
  assign out_if.miss_total     = miss_cnt_r;
  assign out_if.eviction_total = evict_cnt_r;

endmodule

// ===== rtl/core/set_assoc_cache_lru_sim_top.sv =====
// Flow: an accepted word passes the request queue, the set read (ST_READ), then
//   execute and write-back (ST_EXEC) into the output register; execute stalls
//   while a held result is not taken. The back end handles one word at a time
//   (row read, then row write-back). Instruction fetches are dropped at the input.
// Reset: synchronous, active low; a clearing pass over all 2**MAX_SET_BITS sets
//   (64 by default) follows, with in ready low; configuration writes are taken.
module set_assoc_cache_lru_sim_top import sacl_pkg::*; #(
  parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = MAX_WAYS_DEF,
  parameter int ADDR_WIDTH   = ADDR_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sacl_in_if.sink     in_if,
  sacl_out_if.source  out_if,
  sacl_cfg_if.sink    cfg_if
);

  localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1);

  back_stat_t              bstat;
  logic                    q_valid;
  logic                    q_modify;
  logic [MAX_SET_BITS-1:0] q_set;
  logic [ADDR_WIDTH-1:0]   q_tag;
  logic [WAY_CNT_W-1:0]    q_ways;

  // front end: configuration, address split, request queue
  sacl_front #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .cfg_if   (cfg_if),
    .bstat    (bstat),
    .q_valid  (q_valid),
    .q_modify (q_modify),
    .q_set    (q_set),
    .q_tag    (q_tag),
    .q_ways   (q_ways)
  );

  // back end: set lookup, LRU update, totals
  sacl_back #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_modify (q_modify),
    .q_set    (q_set),
    .q_tag    (q_tag),
    .q_ways   (q_ways),
    .bstat    (bstat),
    .out_if   (out_if)
  );

  // no word taken while the set memory is being cleared
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.clearing |-> !in_if.ready)
    else $error("input taken during clearing pass");

  // back end only pops a queue that holds a word
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.pop |-> q_valid)
    else $error("pop from empty queue");

  // one word at a time: a pop is followed by its execute cycle
  a_pop_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.pop |=> !bstat.pop)
    else $error("back-to-back pops");

endmodule
